// ===== hw/rtl/grid_ray_caster_column_macros.svh =====
// ----------------------------------------------------------------------------
// Grid ray caster assertion macros
// Concurrent checks on the clock and reset of the including module.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_CASTER_COLUMN_MACROS_SVH
`define GRID_RAY_CASTER_COLUMN_MACROS_SVH
`ifndef SYNTHESIS
`define GRC_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define GRC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GRC_ASSERT_IMPL(lbl, ante, cons)
`define GRC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid ray caster package
// Shared constants, codes, a distance type and a saturating helper function.
// ----------------------------------------------------------------------------
package grc_pkg;
   localparam int MAP_DIM   = 64;
   localparam int TEX_WIDTH = 64;
   localparam int TEX_COUNT = 10;
   localparam int ADDR_W    = 12;
   localparam int DEPTH     = 4096;
   localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

   localparam logic [1:0] ST_HIT      = 2'd0;
   localparam logic [1:0] ST_LEFT     = 2'd1;
   localparam logic [1:0] ST_TEXRANGE = 2'd2;

   localparam logic [2:0] REG_POS_X   = 3'd0;
   localparam logic [2:0] REG_POS_Y   = 3'd1;
   localparam logic [2:0] REG_DIR_X   = 3'd2;
   localparam logic [2:0] REG_DIR_Y   = 3'd3;
   localparam logic [2:0] REG_PLANE_X = 3'd4;
   localparam logic [2:0] REG_PLANE_Y = 3'd5;
   localparam logic [2:0] REG_SCR_W   = 3'd6;
   localparam logic [2:0] REG_SCR_H   = 3'd7;

   typedef logic [30:0] dist_type;

   function automatic dist_type sat_dist(input logic [36:0] v);
      if (v > {6'd0, DIST_MAX}) begin
         return DIST_MAX;
      end
      return v[30:0];
   endfunction
endpackage

// ===== hw/rtl/grid_ray_caster_column.sv =====
// ----------------------------------------------------------------------------
// Grid ray caster column
// Loads a tile map and casts one DDA ray per requested screen column.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Contents
// req      in         valid / stall      kind, column, cell_index, cell_value
// rsp      out        valid / stall      column, status, side, distance, slice
// csr      in         valid / ready      register index, write data
//
// A map write is done as the request is taken. A cast runs four serial
// divisions, five multiplies and a DDA walk that steps and checks one grid
// cell at a time; no request is taken until its result has been delivered.
// After reset all 4096 map entries are cleared before a request is taken.
// A finished result is held until the receiver stops stalling it.
// ----------------------------------------------------------------------------
module grid_ray_caster_column
   import grc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [10:0]        req_column,
   input  logic [11:0]        req_cell_index,
   input  logic [7:0]         req_cell_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [10:0]        rsp_out_column,
   output logic [1:0]         rsp_status,
   output logic               rsp_side,
   output logic [30:0]        rsp_perp_dist,
   output logic [15:0]        rsp_line_height,
   output logic signed [15:0] rsp_draw_start,
   output logic [7:0]         rsp_tex_index,
   output logic [5:0]         rsp_tex_column,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [21:0]        csr_data
);

`include "grid_ray_caster_column_macros.svh"

   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_DCAM  = 5'd2;
   localparam logic [4:0] S_MULX  = 5'd3;
   localparam logic [4:0] S_MULY  = 5'd4;
   localparam logic [4:0] S_RAYY  = 5'd5;
   localparam logic [4:0] S_DX    = 5'd6;
   localparam logic [4:0] S_DY    = 5'd7;
   localparam logic [4:0] S_MSX   = 5'd8;
   localparam logic [4:0] S_MSY   = 5'd9;
   localparam logic [4:0] S_MSE   = 5'd10;
   localparam logic [4:0] S_STEP  = 5'd11;
   localparam logic [4:0] S_CHK   = 5'd12;
   localparam logic [4:0] S_PERP  = 5'd13;
   localparam logic [4:0] S_DLH   = 5'd14;
   localparam logic [4:0] S_WMUL  = 5'd15;
   localparam logic [4:0] S_FIN   = 5'd16;
   localparam logic [4:0] S_OUT   = 5'd17;

   logic [4:0]         state_ff, state_in;
   logic [11:0]        clr_cnt_ff, clr_cnt_in;
   logic [21:0]        pos_x_ff, pos_y_ff;
   logic signed [17:0] dir_x_ff, dir_y_ff;
   logic signed [19:0] plane_x_ff, plane_y_ff;
   logic [11:0]        sw_ff, sh_ff;
   logic [10:0]        col_ff, col_in;
   logic [32:0]        dnum_ff, dnum_in;
   logic [30:0]        drem_ff, drem_in;
   logic [30:0]        dden_ff, dden_in;
   logic [5:0]         dcnt_ff, dcnt_in;
   logic signed [52:0] mul_ff;
   logic signed [31:0] mul_a;
   logic signed [20:0] mul_b;
   logic signed [20:0] ray_x_ff, ray_x_in, ray_y_ff, ray_y_in;
   dist_type           dlt_x_ff, dlt_x_in, dlt_y_ff, dlt_y_in;
   dist_type           sd_x_ff, sd_x_in, sd_y_ff, sd_y_in;
   logic signed [7:0]  map_x_ff, map_x_in, map_y_ff, map_y_in;
   logic               side_ff, side_in, hit_ff, hit_in;
   logic [7:0]         cell_ff, cell_in;
   dist_type           perp_ff, perp_in;
   logic [15:0]        lh_ff, lh_in;
   logic [7:0]         tile_mem_ff [DEPTH];
   logic [7:0]         cell_rd_ff;
   logic               mem_we;
   logic [11:0]        mem_waddr, mem_raddr;
   logic [7:0]         mem_wdata;
   logic               req_accept, fin;
   logic signed [17:0] cam;
   logic [31:0]        rem_sh;
   logic               div_ge, div_last, div_run;
   logic [16:0]        frac;
   logic signed [52:0] mul_sh;
   logic [31:0]        sum_x, sum_y;
   logic signed [7:0]  nx, ny;
   logic               out_map;
   logic [15:0]        wall_f;
   logic [26:0]        tex_prod;
   logic [10:0]        tex_c, tex_m;
   logic [7:0]         tex_idx;
   logic [1:0]         status_c;
   logic               mirror;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = (state_ff == S_OUT);
   assign fin        = (state_ff == S_FIN);

   assign cam     = $signed({1'b0, dnum_ff[16:0]}) - 18'sd65536;
   assign rem_sh  = {drem_ff, dnum_ff[32]};
   assign div_ge  = rem_sh >= {1'b0, dden_ff};
   assign div_last = (dcnt_ff == 6'd32);
   assign div_run = (state_ff == S_DCAM) || (state_ff == S_DX) ||
                    (state_ff == S_DY) || (state_ff == S_DLH);
   assign mul_sh  = mul_ff >>> 16;
   assign sum_x   = {1'b0, sd_x_ff} + {1'b0, dlt_x_ff};
   assign sum_y   = {1'b0, sd_y_ff} + {1'b0, dlt_y_ff};

   always_comb begin
      frac = 17'd0;
      if (state_ff == S_MSX) begin
         frac = ray_x_ff[20] ? {1'b0, pos_x_ff[15:0]} : 17'd65536 - {1'b0, pos_x_ff[15:0]};
      end else begin
         frac = ray_y_ff[20] ? {1'b0, pos_y_ff[15:0]} : 17'd65536 - {1'b0, pos_y_ff[15:0]};
      end
   end

   always_comb begin
      mul_a = 32'sd0;
      mul_b = 21'sd0;
      case (state_ff)
         S_MULX: begin
            mul_a = 32'(plane_x_ff);
            mul_b = 21'(cam);
         end
         S_MULY: begin
            mul_a = 32'(plane_y_ff);
            mul_b = 21'(cam);
         end
         S_MSX: begin
            mul_a = $signed({1'b0, dlt_x_ff});
            mul_b = $signed({4'd0, frac});
         end
         S_MSY: begin
            mul_a = $signed({1'b0, dlt_y_ff});
            mul_b = $signed({4'd0, frac});
         end
         S_WMUL: begin
            mul_a = $signed({1'b0, perp_ff});
            mul_b = side_ff ? ray_x_ff : ray_y_ff;
         end
         default: begin
            mul_a = 32'sd0;
            mul_b = 21'sd0;
         end
      endcase
   end

   always_comb begin
      if (sd_x_ff < sd_y_ff) begin
         nx = map_x_ff + (ray_x_ff[20] ? -8'sd1 : 8'sd1);
         ny = map_y_ff;
      end else begin
         nx = map_x_ff;
         ny = map_y_ff + (ray_y_ff[20] ? -8'sd1 : 8'sd1);
      end
      out_map   = nx[7] || ny[7] || (int'(nx) >= MAP_DIM) || (int'(ny) >= MAP_DIM);
      mem_raddr = ADDR_W'(int'(ny) * MAP_DIM + int'(nx));
   end

   always_comb begin
      wall_f   = (side_ff ? pos_x_ff[15:0] : pos_y_ff[15:0]) + mul_ff[31:16];
      tex_prod = 27'(wall_f) * 27'(TEX_WIDTH);
      tex_c    = tex_prod[26:16];
      mirror   = (!side_ff && !ray_x_ff[20] && (ray_x_ff != 21'sd0)) ||
                 (side_ff && ray_y_ff[20]);
      tex_m    = mirror ? 11'(TEX_WIDTH - 1) - tex_c : tex_c;
      tex_idx  = cell_ff - 8'd1;
      if (!hit_ff) begin
         status_c = ST_LEFT;
      end else if (int'(tex_idx) >= TEX_COUNT) begin
         status_c = ST_TEXRANGE;
      end else begin
         status_c = ST_HIT;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = req_cell_index;
      mem_wdata = req_cell_value;
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = 8'd0;
      end else if (req_accept && req_kind) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      col_in     = col_ff;
      dnum_in    = dnum_ff;
      drem_in    = drem_ff;
      dden_in    = dden_ff;
      dcnt_in    = dcnt_ff;
      ray_x_in   = ray_x_ff;
      ray_y_in   = ray_y_ff;
      dlt_x_in   = dlt_x_ff;
      dlt_y_in   = dlt_y_ff;
      sd_x_in    = sd_x_ff;
      sd_y_in    = sd_y_ff;
      map_x_in   = map_x_ff;
      map_y_in   = map_y_ff;
      side_in    = side_ff;
      hit_in     = hit_ff;
      cell_in    = cell_ff;
      perp_in    = perp_ff;
      lh_in      = lh_ff;
      if (div_run) begin
         dnum_in = {dnum_ff[31:0], div_ge};
         drem_in = div_ge ? 31'(rem_sh - {1'b0, dden_ff}) : rem_sh[30:0];
         dcnt_in = dcnt_ff + 6'd1;
      end
      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 12'd1;
            if (clr_cnt_ff == 12'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept && !req_kind && ({1'b0, req_column} < sw_ff)) begin
               col_in   = req_column;
               dnum_in  = {5'd0, req_column, 17'd0};
               drem_in  = 31'd0;
               dden_in  = {19'd0, sw_ff};
               dcnt_in  = 6'd0;
               hit_in   = 1'b0;
               state_in = S_DCAM;
            end
         end
         S_DCAM: begin
            if (div_last) begin
               state_in = S_MULX;
            end
         end
         S_MULX: begin
            state_in = S_MULY;
         end
         S_MULY: begin
            ray_x_in = 21'(dir_x_ff) + mul_sh[20:0];
            state_in = S_RAYY;
         end
         S_RAYY: begin
            ray_y_in = 21'(dir_y_ff) + mul_sh[20:0];
            dnum_in  = {1'b1, 32'd0};
            drem_in  = 31'd0;
            dden_in  = 31'(ray_x_ff[20] ? -ray_x_ff : ray_x_ff);
            dcnt_in  = 6'd0;
            state_in = S_DX;
         end
         S_DX: begin
            if (div_last) begin
               dlt_x_in = sat_dist({4'd0, dnum_in});
               dnum_in  = {1'b1, 32'd0};
               drem_in  = 31'd0;
               dden_in  = 31'(ray_y_ff[20] ? -ray_y_ff : ray_y_ff);
               dcnt_in  = 6'd0;
               state_in = S_DY;
            end
         end
         S_DY: begin
            if (div_last) begin
               dlt_y_in = sat_dist({4'd0, dnum_in});
               state_in = S_MSX;
            end
         end
         S_MSX: begin
            state_in = S_MSY;
         end
         S_MSY: begin
            sd_x_in  = sat_dist(mul_ff[52:16]);
            state_in = S_MSE;
         end
         S_MSE: begin
            sd_y_in  = sat_dist(mul_ff[52:16]);
            map_x_in = {2'd0, pos_x_ff[21:16]};
            map_y_in = {2'd0, pos_y_ff[21:16]};
            state_in = S_STEP;
         end
         S_STEP: begin
            if (sd_x_ff < sd_y_ff) begin
               sd_x_in = sat_dist({5'd0, sum_x});
               side_in = 1'b0;
            end else begin
               sd_y_in = sat_dist({5'd0, sum_y});
               side_in = 1'b1;
            end
            map_x_in = nx;
            map_y_in = ny;
            state_in = out_map ? S_PERP : S_CHK;
         end
         S_CHK: begin
            if (cell_rd_ff != 8'd0) begin
               hit_in   = 1'b1;
               cell_in  = cell_rd_ff;
               state_in = S_PERP;
            end else begin
               state_in = S_STEP;
            end
         end
         S_PERP: begin
            if (side_ff) begin
               perp_in = (sd_y_ff >= dlt_y_ff) ? sd_y_ff - dlt_y_ff : 31'd0;
            end else begin
               perp_in = (sd_x_ff >= dlt_x_ff) ? sd_x_ff - dlt_x_ff : 31'd0;
            end
            dnum_in  = {5'd0, sh_ff, 16'd0};
            drem_in  = 31'd0;
            dden_in  = perp_in;
            dcnt_in  = 6'd0;
            state_in = S_DLH;
         end
         S_DLH: begin
            if (div_last) begin
               lh_in    = (dnum_in > 33'd65535) ? 16'hFFFF : dnum_in[15:0];
               state_in = S_WMUL;
            end
         end
         S_WMUL: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tile_mem_ff[mem_waddr] <= mem_wdata;
      end
      cell_rd_ff <= tile_mem_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= 12'd0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= 22'd0;
         pos_y_ff   <= 22'd0;
         dir_x_ff   <= 18'sd65536;
         dir_y_ff   <= 18'sd0;
         plane_x_ff <= 20'sd0;
         plane_y_ff <= 20'sd43690;
         sw_ff      <= 12'd640;
         sh_ff      <= 12'd480;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_POS_X:   pos_x_ff   <= csr_data;
            REG_POS_Y:   pos_y_ff   <= csr_data;
            REG_DIR_X:   dir_x_ff   <= csr_data[17:0];
            REG_DIR_Y:   dir_y_ff   <= csr_data[17:0];
            REG_PLANE_X: plane_x_ff <= csr_data[19:0];
            REG_PLANE_Y: plane_y_ff <= csr_data[19:0];
            REG_SCR_W:   sw_ff      <= csr_data[11:0];
            REG_SCR_H:   sh_ff      <= csr_data[11:0];
            default:     sw_ff      <= sw_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      dnum_ff  <= dnum_in;
      drem_ff  <= drem_in;
      dden_ff  <= dden_in;
      dcnt_ff  <= dcnt_in;
      mul_ff   <= mul_a * mul_b;
      ray_x_ff <= ray_x_in;
      ray_y_ff <= ray_y_in;
      dlt_x_ff <= dlt_x_in;
      dlt_y_ff <= dlt_y_in;
      sd_x_ff  <= sd_x_in;
      sd_y_ff  <= sd_y_in;
      map_x_ff <= map_x_in;
      map_y_ff <= map_y_in;
      side_ff  <= side_in;
      hit_ff   <= hit_in;
      cell_ff  <= cell_in;
      perp_ff  <= perp_in;
      lh_ff    <= lh_in;
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         rsp_out_column  <= col_ff;
         rsp_status      <= status_c;
         rsp_side        <= side_ff;
         rsp_perp_dist   <= perp_ff;
         rsp_line_height <= lh_ff;
         rsp_draw_start  <= $signed({5'd0, sh_ff[11:1]}) - $signed({1'b0, lh_ff[15:1]});
         rsp_tex_index   <= hit_ff ? tex_idx : 8'd0;
         rsp_tex_column  <= (status_c == ST_HIT) ? tex_m[5:0] : 6'd0;
      end
   end

   `GRC_ASSERT_IMPL(a_no_accept_while_result, rsp_valid, req_stall)
   `GRC_ASSERT_NEXT(a_step_then_check, state_ff == S_STEP, (state_ff == S_CHK) || (state_ff == S_PERP))
   `GRC_ASSERT_IMPL(a_clear_no_result, state_ff == S_CLEAR, !rsp_valid && req_stall)

endmodule
